>>> hdl/assert_macros.svh
// Assertion macros shared by the heading turn controller RTL.
// Standalone header: no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/htp_pkg.sv
// Package for the heading turn controller: widths, register codes, payload types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package htp_pkg;

    // Field widths
    localparam int HEADING_W         = 13;
    localparam int HEADING_FRAC_BITS = 4;
    localparam int GAIN_W            = 24;
    localparam int THR_W             = 8;
    localparam int ERR_W             = 8;
    localparam int POWER_W           = 16;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 24;
    localparam int DEG_W             = HEADING_W - HEADING_FRAC_BITS;

    // One full turn in heading units
    localparam logic [HEADING_W-1:0] FULL_CIRCLE = HEADING_W'(360 << HEADING_FRAC_BITS);
    localparam logic [ERR_W-1:0]     HALF_CIRCLE_DEG = ERR_W'(180);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = 3'd4;

    // Register reset values
    localparam logic [HEADING_W-1:0] RST_TARGET = '0;
    localparam logic [GAIN_W-1:0]    RST_GAIN_P = 24'd25559;
    localparam logic [GAIN_W-1:0]    RST_GAIN_I = 24'd59;
    localparam logic [GAIN_W-1:0]    RST_GAIN_D = 24'd32768;
    localparam logic [THR_W-1:0]     RST_SETTLE = 8'd3;

    typedef logic [HEADING_W-1:0] heading_t;

    typedef struct packed {
        heading_t heading;
    } sample_t;

    typedef struct packed {
        logic signed [POWER_W-1:0] drive_power;
        logic                      turn_clockwise;
        logic                      settled;
        logic [ERR_W-1:0]          heading_error;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_wr_t;

    // Error stage result handed to the gain stage
    typedef struct packed {
        logic [ERR_W-1:0]        err;
        logic                    clockwise;
        logic                    settled;
        logic signed [ERR_W:0]   deriv;
    } track_t;

    // Reduce a heading into one turn; inputs stay below two turns
    function automatic heading_t mod_circle(input heading_t v);
        mod_circle = (v >= FULL_CIRCLE) ? v - FULL_CIRCLE : v;
    endfunction

endpackage

`default_nettype wire

>>> hdl/htp_stream_if.sv
// Valid/ready channel interface used by every port of the heading turn controller.
// Payload type is supplied by the instantiating scope (see htp_pkg).
`timescale 1ns / 1ps
`default_nettype none

interface htp_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/htp_track.sv
// Error stage: wraparound distance, direction, saturating integral and settle state.
// Depends on htp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module htp_track #(
    parameter int SUM_WIDTH = 20
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire htp_pkg::heading_t             heading,
    input  wire htp_pkg::heading_t             target,
    input  wire logic [htp_pkg::THR_W-1:0]     threshold,
    output htp_pkg::track_t                    track,
    output logic [SUM_WIDTH-1:0]               error_sum
);

    htp_pkg::heading_t                 h;
    htp_pkg::heading_t                 cw_full;
    htp_pkg::heading_t                 ccw_full;
    logic [htp_pkg::DEG_W-1:0]         cw_deg;
    logic [htp_pkg::DEG_W-1:0]         ccw_deg;
    logic [htp_pkg::ERR_W-1:0]         err;
    logic                              clockwise;
    logic [SUM_WIDTH:0]                sum_add;
    logic [SUM_WIDTH-1:0]              sum_next;
    logic                              settle_now;
    logic signed [htp_pkg::ERR_W:0]    deriv;

    logic [SUM_WIDTH-1:0]              sum_reg;
    logic [htp_pkg::ERR_W-1:0]         last_reg;
    logic                              finished_reg;
    htp_pkg::track_t                   track_reg;
    logic [SUM_WIDTH-1:0]              sum_out_reg;

    // Distances both ways around the circle, in whole degrees
    always_comb
    begin
        h        = htp_pkg::mod_circle(heading);
        cw_full  = (target >= h) ? target - h : htp_pkg::FULL_CIRCLE - h + target;
        ccw_full = (h >= target) ? h - target : htp_pkg::FULL_CIRCLE + h - target;
        cw_deg   = cw_full[htp_pkg::HEADING_W-1:htp_pkg::HEADING_FRAC_BITS];
        ccw_deg  = ccw_full[htp_pkg::HEADING_W-1:htp_pkg::HEADING_FRAC_BITS];
        // a tie turns counter-clockwise; the shorter side never exceeds 180
        clockwise = (cw_deg < ccw_deg);
        err       = clockwise ? cw_deg[htp_pkg::ERR_W-1:0] : ccw_deg[htp_pkg::ERR_W-1:0];
    end

    // Saturating integral, cleared on zero error or an error larger than the target heading
    always_comb
    begin
        sum_add = {1'b0, sum_reg} + (SUM_WIDTH + 1)'(err);
        sum_next = sum_add[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : sum_add[SUM_WIDTH-1:0];
        if ((err == '0) ||
            (htp_pkg::HEADING_W'({err, {htp_pkg::HEADING_FRAC_BITS{1'b0}}}) > target))
        begin
            sum_next = '0;
        end
        settle_now = (err < threshold);
        deriv      = $signed({1'b0, err}) - $signed({1'b0, last_reg});
    end

    // Controller state; frozen once the turn has finished
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= '0;
            last_reg     <= '0;
            finished_reg <= 1'b0;
        end
        else if (load && !finished_reg)
        begin
            sum_reg  <= sum_next;
            last_reg <= err;
            if (settle_now)
            begin
                finished_reg <= 1'b1;
            end
        end
    end

    // Stage output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            track_reg.err       <= err;
            track_reg.clockwise <= clockwise;
            track_reg.settled   <= finished_reg || settle_now;
            track_reg.deriv     <= deriv;
            sum_out_reg         <= sum_next;
        end
    end

    assign track     = track_reg;
    assign error_sum = sum_out_reg;

    `ASSERT_NEXT(a_finished_sticky, clk, rst_n, finished_reg, finished_reg)
    `ASSERT_NEXT(a_state_frozen, clk, rst_n, finished_reg,
                 $stable(sum_reg) && $stable(last_reg))
    `ASSERT_NEXT(a_zero_err_clears, clk, rst_n, load && !finished_reg && (err == '0),
                 sum_reg == '0)

endmodule

`default_nettype wire

>>> hdl/heading_turn_pid_core.sv
// Heading turn PID controller, top level: config registers, pipeline, gain products.
// Depends on htp_pkg, htp_stream_if, htp_track and assert_macros.svh.
// Registers from sample accept to result valid: input, error, product, output.
// Throughput: one sample per cycle while no result waits; the sample-to-sample state loop closes in the error stage.
// Ready chains back combinationally; a waiting result stalls only the full stages behind it.
// Reset: integral, last error and finished flag cleared; registers take their defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module heading_turn_pid_core #(
    parameter int SUM_WIDTH = 20
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    htp_stream_if.sink   sample,
    htp_stream_if.source result,
    htp_stream_if.sink   cfg
);

    localparam int RAW_W  = SUM_WIDTH + 27;
    localparam int PP_P_W = htp_pkg::ERR_W + htp_pkg::GAIN_W;
    localparam int PP_I_W = SUM_WIDTH + htp_pkg::GAIN_W;
    localparam int PP_D_W = htp_pkg::ERR_W + 1 + htp_pkg::GAIN_W + 1;
    localparam int Q_W    = RAW_W - 8;

    // Configuration registers
    htp_pkg::heading_t               target_reg;
    logic [htp_pkg::GAIN_W-1:0]      gain_p_reg;
    logic [htp_pkg::GAIN_W-1:0]      gain_i_reg;
    logic [htp_pkg::GAIN_W-1:0]      gain_d_reg;
    logic [htp_pkg::THR_W-1:0]       thr_reg;

    // Pipeline control
    logic in_valid_reg;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic adv0;
    logic adv1;
    logic adv2;
    logic adv3;

    // Pipeline payload
    htp_pkg::heading_t               heading_reg;
    htp_pkg::track_t                 s1;
    logic [SUM_WIDTH-1:0]            s1_sum;
    logic [PP_P_W-1:0]               pp_p_reg;
    logic [PP_I_W-1:0]               pp_i_reg;
    logic signed [PP_D_W-1:0]        pp_d_reg;
    logic signed [PP_D_W-1:0]        pp_d_next;
    logic [htp_pkg::ERR_W-1:0]       s2_err_reg;
    logic                            s2_cw_reg;
    logic                            s2_settled_reg;
    htp_pkg::result_t                out_reg;

    logic signed [RAW_W-1:0]         raw;
    logic signed [Q_W-1:0]           q;
    logic [Q_W-16:0]                 q_hi;
    logic signed [htp_pkg::POWER_W-1:0] power_next;

    // Config writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= htp_pkg::RST_TARGET;
            gain_p_reg <= htp_pkg::RST_GAIN_P;
            gain_i_reg <= htp_pkg::RST_GAIN_I;
            gain_d_reg <= htp_pkg::RST_GAIN_D;
            thr_reg    <= htp_pkg::RST_SETTLE;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                htp_pkg::REG_TARGET:
                    target_reg <= htp_pkg::mod_circle(cfg.data.value[htp_pkg::HEADING_W-1:0]);
                htp_pkg::REG_GAIN_P: gain_p_reg <= cfg.data.value;
                htp_pkg::REG_GAIN_I: gain_i_reg <= cfg.data.value;
                htp_pkg::REG_GAIN_D: gain_d_reg <= cfg.data.value;
                htp_pkg::REG_SETTLE: thr_reg    <= cfg.data.value[htp_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Each stage moves when the next one is empty or moving
    assign adv3 = !out_valid_reg || result.ready;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;
    assign adv0 = !in_valid_reg || adv1;
    assign sample.ready = adv0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv0)
            begin
                in_valid_reg <= sample.valid;
            end
            if (adv1)
            begin
                s1_valid_reg <= in_valid_reg;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (adv0 && sample.valid)
        begin
            heading_reg <= sample.data.heading;
        end
    end

    // Error and integral stage
    htp_track #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_valid_reg && adv1),
        .heading   (heading_reg),
        .target    (target_reg),
        .threshold (thr_reg),
        .track     (s1),
        .error_sum (s1_sum)
    );

    // Gain products, one multiplier per term
    assign pp_d_next = s1.deriv * $signed({1'b0, gain_d_reg});

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            pp_p_reg       <= s1.err * gain_p_reg;
            pp_i_reg       <= s1_sum * gain_i_reg;
            pp_d_reg       <= pp_d_next;
            s2_err_reg     <= s1.err;
            s2_cw_reg      <= s1.clockwise;
            s2_settled_reg <= s1.settled;
        end
    end

    // Sum of terms, floor divide by 256, saturate to the power range; zero power once settled
    always_comb
    begin
        raw = $signed({{(RAW_W - PP_P_W){1'b0}}, pp_p_reg})
            + $signed({{(RAW_W - PP_I_W){1'b0}}, pp_i_reg})
            + $signed({{(RAW_W - PP_D_W){pp_d_reg[PP_D_W-1]}}, pp_d_reg});
        q    = raw[RAW_W-1:8];
        q_hi = q[Q_W-1:15];
        if ((&q_hi) || !(|q_hi))
        begin
            power_next = q[htp_pkg::POWER_W-1:0];
        end
        else if (q[Q_W-1])
        begin
            power_next = 16'sh8000;
        end
        else
        begin
            power_next = 16'sh7FFF;
        end
        if (s2_settled_reg)
        begin
            power_next = '0;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (adv3 && s2_valid_reg)
        begin
            out_reg.drive_power    <= power_next;
            out_reg.turn_clockwise <= s2_cw_reg;
            out_reg.settled        <= s2_settled_reg;
            out_reg.heading_error  <= s2_err_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    `ASSERT_NOW(a_settled_no_power, clk, rst_n, out_valid_reg && out_reg.settled,
                out_reg.drive_power == '0)
    `ASSERT_NOW(a_err_half_turn, clk, rst_n, out_valid_reg,
                out_reg.heading_error <= htp_pkg::HALF_CIRCLE_DEG)
    `ASSERT_NOW(a_cw_short_side, clk, rst_n, out_valid_reg && out_reg.turn_clockwise,
                out_reg.heading_error < htp_pkg::HALF_CIRCLE_DEG)

endmodule

`default_nettype wire

>>> tb/tb_heading_turn_pid_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for heading_turn_pid_core: heading samples go in, PID results are
// compared field by field against an in-bench predictor of the turn controller.
// Depends on htp_pkg, htp_stream_if and the core RTL.

module tb_heading_turn_pid_core;

    localparam int     SUM_W       = 20;
    localparam int     FULL_UNITS  = 360 << htp_pkg::HEADING_FRAC_BITS;
    localparam longint SUM_MAX     = (longint'(1) << SUM_W) - 1;
    localparam int     PIPE_LAT    = 4;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     SHOW_MAX    = 10;
    localparam int     TGT_PAD     = htp_pkg::CFG_DATA_W - htp_pkg::HEADING_W;
    localparam int     THR_PAD     = htp_pkg::CFG_DATA_W - htp_pkg::THR_W;
    localparam int     LAST_INDEX  = (1 << htp_pkg::CFG_IDX_W) - 1;

    logic clk;
    logic rst_n;

    htp_stream_if #(.payload_t(htp_pkg::sample_t)) sample_ch ();
    htp_stream_if #(.payload_t(htp_pkg::result_t)) result_ch ();
    htp_stream_if #(.payload_t(htp_pkg::cfg_wr_t)) cfg_ch ();

    heading_turn_pid_core #(.SUM_WIDTH(SUM_W)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Predictor copy of registers and loop state
    logic [htp_pkg::HEADING_W-1:0] cur_target;
    logic [htp_pkg::GAIN_W-1:0]    cur_kp;
    logic [htp_pkg::GAIN_W-1:0]    cur_ki;
    logic [htp_pkg::GAIN_W-1:0]    cur_kd;
    logic [htp_pkg::THR_W-1:0]     cur_settle;
    longint                        integ_sum;
    int unsigned                   prev_err;
    bit                            turn_done;

    htp_pkg::result_t expected_turns[$];

    int unsigned cycle_count;
    int unsigned samples_sent;
    int unsigned results_seen;
    int unsigned settled_seen;
    int unsigned cfg_writes;
    int unsigned fail_count;

    bit          tx_gaps;
    bit          rx_stalls;
    int unsigned hold_left;
    int unsigned stall_left;

    // Clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_turns.size());
            $display("FAIL heading_turn_pid_core");
            $finish;
        end
    end

    // Result receiver: long hold-off on request, otherwise short random stalls
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (stall_left > 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (rx_stalls && $urandom_range(0, 6) == 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge clk)
    begin : check_results
        htp_pkg::result_t want;
        htp_pkg::result_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            results_seen++;
            if (got.settled)
                settled_seen++;
            if (expected_turns.size() == 0)
            begin
                fail_count++;
                if (fail_count <= SHOW_MAX)
                    $display("unexpected result at cycle %0d: power %0d err %0d",
                             cycle_count, got.drive_power, got.heading_error);
            end
            else
            begin
                want = expected_turns.pop_front();
                if (got.drive_power !== want.drive_power
                    || got.turn_clockwise !== want.turn_clockwise
                    || got.settled !== want.settled
                    || got.heading_error !== want.heading_error)
                begin
                    fail_count++;
                    if (fail_count <= SHOW_MAX)
                        $display({"result %0d mismatch (exp/act): power %0d/%0d ",
                                  "cw %0b/%0b settled %0b/%0b err %0d/%0d"},
                                 results_seen, want.drive_power, got.drive_power,
                                 want.turn_clockwise, got.turn_clockwise,
                                 want.settled, got.settled,
                                 want.heading_error, got.heading_error);
                end
            end
        end
    end

    // Expected result of one heading sample; advances the predictor state
    function automatic htp_pkg::result_t predict_turn(input htp_pkg::heading_t hd);
        int unsigned      h;
        int unsigned      t;
        int unsigned      cw;
        int unsigned      ccw;
        int unsigned      err;
        bit               cwise;
        longint           deriv;
        longint           raw;
        longint           pwr;
        htp_pkg::result_t r;
        h = int'(hd) % FULL_UNITS;
        t = int'(cur_target) % FULL_UNITS;
        cw  = (t >= h) ? t - h : FULL_UNITS - h + t;
        ccw = (h >= t) ? h - t : FULL_UNITS + h - t;
        cw  = cw >> htp_pkg::HEADING_FRAC_BITS;
        ccw = ccw >> htp_pkg::HEADING_FRAC_BITS;
        // tie goes counter-clockwise
        cwise = (cw < ccw);
        err = cwise ? cw : ccw;
        pwr = 0;
        if (!turn_done)
        begin
            integ_sum += err;
            if (integ_sum > SUM_MAX)
                integ_sum = SUM_MAX;
            // integral clears on zero error or an error larger than the target angle
            if (err == 0 || (err << htp_pkg::HEADING_FRAC_BITS) > t)
                integ_sum = 0;
            deriv = longint'(err) - longint'(prev_err);
            raw = longint'(err) * longint'(cur_kp) + integ_sum * longint'(cur_ki)
                + deriv * longint'(cur_kd);
            pwr = raw >>> 8;
            if (pwr > 32767)
                pwr = 32767;
            if (pwr < -32768)
                pwr = -32768;
            prev_err = err;
            if (err < cur_settle)
            begin
                turn_done = 1'b1;
                pwr = 0;
            end
        end
        r.drive_power    = pwr[htp_pkg::POWER_W-1:0];
        r.turn_clockwise = cwise;
        r.settled        = turn_done;
        r.heading_error  = err[htp_pkg::ERR_W-1:0];
        return r;
    endfunction

    // Offer one heading sample, optionally after a short gap
    task automatic send_heading(input htp_pkg::heading_t hd);
        if (tx_gaps && $urandom_range(0, 4) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= htp_pkg::sample_t'(hd);
        do @(posedge clk); while (!sample_ch.ready);
        expected_turns.push_back(predict_turn(hd));
        samples_sent++;
    endtask

    // Stop offering samples and wait for the pipeline to empty
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_turns.size() != 0);
        repeat (PIPE_LAT + 2) @(posedge clk);
    endtask

    // Register write on an idle block
    task automatic write_reg(input logic [htp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [htp_pkg::CFG_DATA_W-1:0] val);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: idx, value: val};
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            htp_pkg::REG_TARGET: cur_target = val[htp_pkg::HEADING_W-1:0];
            htp_pkg::REG_GAIN_P: cur_kp     = val[htp_pkg::GAIN_W-1:0];
            htp_pkg::REG_GAIN_I: cur_ki     = val[htp_pkg::GAIN_W-1:0];
            htp_pkg::REG_GAIN_D: cur_kd     = val[htp_pkg::GAIN_W-1:0];
            htp_pkg::REG_SETTLE: cur_settle = val[htp_pkg::THR_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    function automatic logic [htp_pkg::CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return {htp_pkg::GAIN_W{1'b1}};
            2, 3: return htp_pkg::CFG_DATA_W'($urandom_range(0, 65535));
            4: return htp_pkg::CFG_DATA_W'($urandom_range(0, 255));
            default: return htp_pkg::CFG_DATA_W'($urandom);
        endcase
    endfunction

    // Target anywhere in the field (upper write bits junk), random gains, no settling
    task automatic random_setup();
        write_reg(htp_pkg::REG_TARGET, {TGT_PAD'($urandom), htp_pkg::heading_t'($urandom)});
        write_reg(htp_pkg::REG_GAIN_P, pick_gain());
        write_reg(htp_pkg::REG_GAIN_I, pick_gain());
        write_reg(htp_pkg::REG_GAIN_D, pick_gain());
        write_reg(htp_pkg::REG_SETTLE, {THR_PAD'($urandom), htp_pkg::THR_W'(0)});
    endtask

    // A turn closing in on the target with jitter, mixed with stray samples
    task automatic run_turn(input int n_items, input int start_off, input int noise_pct);
        int off;
        int t;
        int h;
        t = int'(cur_target) % FULL_UNITS;
        off = start_off;
        for (int k = 0; k < n_items; k++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                send_heading(htp_pkg::heading_t'($urandom));
            end
            else
            begin
                off = off - off / 8 + int'($urandom_range(0, 24)) - 12;
                h = ((t + off) % FULL_UNITS + FULL_UNITS) % FULL_UNITS;
                // same bearing presented one full turn higher
                if (h + FULL_UNITS < (1 << htp_pkg::HEADING_W) && $urandom_range(0, 19) == 0)
                    h += FULL_UNITS;
                send_heading(htp_pkg::heading_t'(h));
            end
        end
    endtask

    function automatic int random_offset();
        return int'($urandom_range(0, 2 * FULL_UNITS / 2)) - FULL_UNITS / 2;
    endfunction

    // Register defaults straight out of reset; errors kept above the default threshold
    task automatic test_reset_defaults();
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        send_heading(htp_pkg::heading_t'(1000));
        send_heading(htp_pkg::heading_t'(2880));
        send_heading(htp_pkg::heading_t'(4000));
        drain_results();
    endtask

    // Wraparound, ties, truncation edges and out-of-range headings and targets
    task automatic test_wrap_and_ties();
        write_reg(htp_pkg::REG_SETTLE, '0);
        write_reg(htp_pkg::REG_TARGET, htp_pkg::CFG_DATA_W'(2880));
        send_heading(htp_pkg::heading_t'(0));
        send_heading(htp_pkg::heading_t'(5759));
        send_heading(htp_pkg::heading_t'(5760));
        send_heading(htp_pkg::heading_t'(8191));
        send_heading(htp_pkg::heading_t'(2880));
        send_heading(htp_pkg::heading_t'(2879));
        send_heading(htp_pkg::heading_t'(2896));
        write_reg(htp_pkg::REG_TARGET, {TGT_PAD'('1), htp_pkg::heading_t'(8191)});
        send_heading(htp_pkg::heading_t'(2431));
        send_heading(htp_pkg::heading_t'(8191));
        send_heading(htp_pkg::heading_t'(7000));
        write_reg(htp_pkg::REG_TARGET, '0);
        send_heading(htp_pkg::heading_t'(15));
        send_heading(htp_pkg::heading_t'(16));
        send_heading(htp_pkg::heading_t'(5744));
        drain_results();
    endtask

    // Largest gains drive both saturation limits, zero gains give zero power
    task automatic test_gain_extremes();
        write_reg(htp_pkg::REG_GAIN_P, {htp_pkg::GAIN_W{1'b1}});
        write_reg(htp_pkg::REG_GAIN_I, {htp_pkg::GAIN_W{1'b1}});
        write_reg(htp_pkg::REG_GAIN_D, {htp_pkg::GAIN_W{1'b1}});
        send_heading(htp_pkg::heading_t'(2880));
        send_heading(htp_pkg::heading_t'(0));
        write_reg(htp_pkg::REG_GAIN_P, '0);
        write_reg(htp_pkg::REG_GAIN_I, '0);
        write_reg(htp_pkg::REG_GAIN_D, '0);
        send_heading(htp_pkg::heading_t'(1000));
        drain_results();
    endtask

    // Writes to indexes past the register list leave everything unchanged
    task automatic test_ignored_index();
        write_reg(htp_pkg::REG_GAIN_P, htp_pkg::CFG_DATA_W'(htp_pkg::RST_GAIN_P));
        for (int i = int'(htp_pkg::REG_SETTLE) + 1; i <= LAST_INDEX; i++)
            write_reg(htp_pkg::CFG_IDX_W'(i),
                      (i == LAST_INDEX) ? '1 : htp_pkg::CFG_DATA_W'($urandom));
        send_heading(htp_pkg::heading_t'(300));
        send_heading(htp_pkg::heading_t'(5500));
        drain_results();
    endtask

    // Random settings, converging turns with stray samples, idling on both sides
    task automatic test_random_turns();
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        for (int p = 0; p < 8; p++)
        begin
            random_setup();
            run_turn(120, random_offset(), 15);
        end
        drain_results();
    endtask

    // Receiver holds off while samples keep coming, so the core fills and stalls
    task automatic test_backpressure();
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        hold_left <= 60;
        run_turn(40, random_offset(), 30);
        drain_results();
    endtask

    // Errors near 180 degrees under a wide target let the integral build up
    task automatic test_integral_buildup();
        write_reg(htp_pkg::REG_TARGET, htp_pkg::CFG_DATA_W'(5000));
        write_reg(htp_pkg::REG_GAIN_P, '0);
        write_reg(htp_pkg::REG_GAIN_I, htp_pkg::CFG_DATA_W'(1));
        write_reg(htp_pkg::REG_GAIN_D, '0);
        write_reg(htp_pkg::REG_SETTLE, '0);
        for (int k = 0; k < 200; k++)
            send_heading(htp_pkg::heading_t'(2120 + $urandom_range(0, 15)));
        drain_results();
    endtask

    // Turn settles, then power stays zero while error and direction keep tracking
    task automatic test_settle_and_hold();
        write_reg(htp_pkg::REG_TARGET,
                  htp_pkg::CFG_DATA_W'($urandom_range(0, FULL_UNITS - 1)));
        write_reg(htp_pkg::REG_GAIN_P, htp_pkg::CFG_DATA_W'(htp_pkg::RST_GAIN_P));
        write_reg(htp_pkg::REG_GAIN_I, htp_pkg::CFG_DATA_W'(htp_pkg::RST_GAIN_I));
        write_reg(htp_pkg::REG_GAIN_D, htp_pkg::CFG_DATA_W'(htp_pkg::RST_GAIN_D));
        write_reg(htp_pkg::REG_SETTLE, htp_pkg::CFG_DATA_W'(20));
        run_turn(60, random_offset(), 0);
        write_reg(htp_pkg::REG_SETTLE, {THR_PAD'($urandom), htp_pkg::THR_W'(180)});
        random_setup();
        write_reg(htp_pkg::REG_SETTLE, htp_pkg::CFG_DATA_W'(htp_pkg::HALF_CIRCLE_DEG));
        run_turn(40, random_offset(), 50);
        drain_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.data = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        hold_left = 0;
        stall_left = 0;
        cur_target = htp_pkg::RST_TARGET;
        cur_kp = htp_pkg::RST_GAIN_P;
        cur_ki = htp_pkg::RST_GAIN_I;
        cur_kd = htp_pkg::RST_GAIN_D;
        cur_settle = htp_pkg::RST_SETTLE;
        integ_sum = 0;
        prev_err = 0;
        turn_done = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_wrap_and_ties();
        test_gain_extremes();
        test_ignored_index();
        test_random_turns();
        test_backpressure();
        test_integral_buildup();
        test_settle_and_hold();

        $display("Sent %0d heading samples, checked %0d results over %0d register writes.",
                 samples_sent, results_seen, cfg_writes);
        $display("Settled results: %0d, mismatches: %0d.", settled_seen, fail_count);
        if (fail_count == 0 && expected_turns.size() == 0)
            $display("PASS heading_turn_pid_core");
        else
            $display("FAIL heading_turn_pid_core");
        $finish;
    end

endmodule
